// ----- sv/pwel_pkg.sv -----
// Shared types and codes of the per-thread wait event logger.
`timescale 1ns / 1ps
package pwel_pkg;

   localparam logic [1:0] MODE_ACTIVATE   = 2'd0;
   localparam logic [1:0] MODE_DEACTIVATE = 2'd1;
   localparam logic [1:0] MODE_RECORD     = 2'd2;
   localparam logic [1:0] MODE_READ       = 2'd3;

   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;
   localparam logic [2:0] ST_NOLOG   = 3'd5;

   localparam int ENTRY_W = 134;   // sec 40, nsec 30, wait 64

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_SCAN  = 8'b0000_0010,
      S_EXEC  = 8'b0000_0100,
      S_SHIFT = 8'b0000_1000,
      S_RREQ  = 8'b0001_0000,
      S_RWAIT = 8'b0010_0000,
      S_OUT   = 8'b0100_0000,
      S_HOLD  = 8'b1000_0000
   } state_type;

endpackage

// ----- sv/per_thread_wait_event_logger.sv -----
// Top level of the per-thread wait event logger.
`timescale 1ns / 1ps
// Usage:
//  req_ carries one operation a beat (mode in tuser, id/threshold/wait/stamp
//  in tdata). rsp_ returns its results; tlast marks the final one.
//  Activate, deactivate, record and invalid reads give one result; a read
//  of a thread with a log gives one result per stored entry, oldest first.
//  Each operation first scans the slot table one slot a cycle through a
//  single id comparator; deactivate then moves each later slot down one
//  place, and a read steps through request, registered ring read and
//  output for each entry. One item is worked at a time: req_tready is low
//  until its last result is taken.
//  Reset empties the table and frees all buffers at once; the ring memory
//  itself is not cleared, as only entries written since activation are read.
//  While rsp_tready is low the pending result is held and the sequencer
//  waits.
module per_thread_wait_event_logger #(
   parameter int TRACKED_MAX = 10,
   parameter int LOG_DEPTH   = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: thread_id[31:0], threshold[95:32], wait_time[159:96],
   //        stamp_sec[199:160], stamp_nsec[229:200], zero fill to 232
   input  logic [231:0] req_tdata,
   // tuser: mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: status[2:0], log_sec[42:3], log_nsec[72:43], log_wait[136:73],
   //        peak_sec[176:137], peak_nsec[206:177], peak_wait[270:207],
   //        event_count[302:271], tracked_total[306:303], zero fill to 312
   output logic [311:0] rsp_tdata,
   output logic         rsp_tlast
);
   localparam int SW = (TRACKED_MAX > 1) ? $clog2(TRACKED_MAX) : 1;
   localparam int CW = $clog2(TRACKED_MAX + 1);
   localparam int PW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int AW = $clog2(TRACKED_MAX * LOG_DEPTH);
   localparam int NW = $clog2(LOG_DEPTH + 1);

   pwel_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff;
   logic [31:0]   sl_thread_ff [TRACKED_MAX];
   logic [63:0]   sl_limit_ff  [TRACKED_MAX];
   logic [31:0]   sl_events_ff [TRACKED_MAX];
   logic [PW-1:0] sl_pos_ff    [TRACKED_MAX];
   logic [63:0]   sl_pwait_ff  [TRACKED_MAX];
   logic [39:0]   sl_psec_ff   [TRACKED_MAX];
   logic [29:0]   sl_pnsec_ff  [TRACKED_MAX];
   logic [SW-1:0] sl_buf_ff    [TRACKED_MAX];
   logic [TRACKED_MAX-1:0] busy_ff;

   logic [1:0]    mode_ff;
   logic [31:0]   tid_ff;
   logic [63:0]   thr_ff, wait_ff;
   logic [39:0]   sec_ff;
   logic [29:0]   nsec_ff;

   logic [CW-1:0] idx_ff;      // scan / shift counter
   logic          hit_ff;
   logic [SW-1:0] hslot_ff;
   logic [NW-1:0] rnum_ff;
   logic [PW-1:0] rptr_ff;
   logic [AW-1:0] rd_addr;
   logic [pwel_pkg::ENTRY_W-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   logic [2:0]    o_status_ff;
   logic [39:0]   o_lsec_ff;
   logic [29:0]   o_lnsec_ff;
   logic [63:0]   o_lwait_ff;
   logic          o_slot_ff, o_last_ff;

   logic tid_pos;
   assign tid_pos = (tid_ff != 32'd0) && !tid_ff[31];

   // lowest free buffer
   logic [SW-1:0] free_buf;
   always_comb begin
      free_buf = '0;
      for (int b = TRACKED_MAX - 1; b >= 0; b--) begin
         if (!busy_ff[b]) free_buf = SW'(b);
      end
   end

   logic [SW-1:0] hb;
   assign hb = sl_buf_ff[hslot_ff];
   assign wr_en = (state_ff == pwel_pkg::S_EXEC) && (mode_ff == pwel_pkg::MODE_RECORD)
                  && hit_ff && !($signed(wait_ff) < $signed(sl_limit_ff[hslot_ff]));
   assign wr_addr = AW'(hb * LOG_DEPTH) + AW'(sl_pos_ff[hslot_ff]);
   assign rd_addr = AW'(hb * LOG_DEPTH) + AW'(rptr_ff);

   pwel_ram #(.WIDTH(pwel_pkg::ENTRY_W), .DEPTH(TRACKED_MAX * LOG_DEPTH)) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data({wait_ff, nsec_ff, sec_ff}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == pwel_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == pwel_pkg::S_OUT);
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {5'd0, 4'(count_ff),
                        o_slot_ff ? sl_events_ff[hslot_ff] : 32'd0,
                        o_slot_ff ? sl_pwait_ff[hslot_ff]  : 64'd0,
                        o_slot_ff ? sl_pnsec_ff[hslot_ff]  : 30'd0,
                        o_slot_ff ? sl_psec_ff[hslot_ff]   : 40'd0,
                        o_lwait_ff, o_lnsec_ff, o_lsec_ff, o_status_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pwel_pkg::S_IDLE:  if (req_tvalid) state_in = pwel_pkg::S_SCAN;
         pwel_pkg::S_SCAN:  if (idx_ff >= count_ff || hit_ff) state_in = pwel_pkg::S_EXEC;
         pwel_pkg::S_EXEC: begin
            // found deactivates shift, logged reads fetch entries, the rest go via S_HOLD
            if (mode_ff == pwel_pkg::MODE_DEACTIVATE && count_ff != '0 && hit_ff)
               state_in = pwel_pkg::S_SHIFT;
            else if (mode_ff == pwel_pkg::MODE_READ && tid_pos && hit_ff
                     && sl_events_ff[hslot_ff] != 32'd0)
               state_in = pwel_pkg::S_RREQ;
            else
               state_in = pwel_pkg::S_HOLD;
         end
         pwel_pkg::S_SHIFT: if (idx_ff >= count_ff) state_in = pwel_pkg::S_OUT;
         pwel_pkg::S_RREQ:  state_in = pwel_pkg::S_RWAIT;
         pwel_pkg::S_RWAIT: state_in = pwel_pkg::S_OUT;
         pwel_pkg::S_OUT:   if (rsp_tready) state_in = o_last_ff ? pwel_pkg::S_IDLE
                                                                 : pwel_pkg::S_RREQ;
         pwel_pkg::S_HOLD:  state_in = pwel_pkg::S_OUT;
         default:           state_in = pwel_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pwel_pkg::S_IDLE;
         count_ff <= '0;
         busy_ff  <= '0;
         for (int i = 0; i < TRACKED_MAX; i++) begin
            sl_thread_ff[i] <= '0; sl_limit_ff[i] <= '0; sl_events_ff[i] <= '0;
            sl_pos_ff[i] <= '0; sl_pwait_ff[i] <= '0; sl_psec_ff[i] <= '0;
            sl_pnsec_ff[i] <= '0; sl_buf_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            pwel_pkg::S_IDLE: if (req_tvalid) begin
               mode_ff <= req_tuser;
               tid_ff  <= req_tdata[31:0];
               thr_ff  <= req_tdata[95:32];
               wait_ff <= req_tdata[159:96];
               sec_ff  <= req_tdata[199:160];
               nsec_ff <= req_tdata[229:200];
               idx_ff  <= '0;
               hit_ff  <= 1'b0;
            end
            pwel_pkg::S_SCAN: if (!(idx_ff >= count_ff || hit_ff)) begin
               // one slot compared per cycle
               if (sl_thread_ff[idx_ff[SW-1:0]] == tid_ff) begin
                  hit_ff   <= 1'b1;
                  hslot_ff <= idx_ff[SW-1:0];
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            pwel_pkg::S_EXEC: begin
               o_lsec_ff  <= '0; o_lnsec_ff <= '0; o_lwait_ff <= '0;
               o_slot_ff  <= 1'b0; o_last_ff <= 1'b1;
               o_status_ff <= pwel_pkg::ST_DONE;
               case (mode_ff)
                  pwel_pkg::MODE_ACTIVATE: begin
                     if (count_ff >= CW'(TRACKED_MAX))
                        o_status_ff <= pwel_pkg::ST_NOSPACE;
                     else if (hit_ff || !tid_pos || thr_ff == 64'd0 || thr_ff[63])
                        o_status_ff <= pwel_pkg::ST_INVALID;
                     else begin
                        sl_thread_ff[count_ff[SW-1:0]] <= tid_ff;
                        sl_limit_ff[count_ff[SW-1:0]]  <= thr_ff;
                        sl_buf_ff[count_ff[SW-1:0]]    <= free_buf;
                        busy_ff[free_buf] <= 1'b1;
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  pwel_pkg::MODE_DEACTIVATE: begin
                     if (count_ff == '0)
                        o_status_ff <= pwel_pkg::ST_EMPTY;
                     else if (!hit_ff)
                        o_status_ff <= pwel_pkg::ST_INVALID;
                     else begin
                        busy_ff[hb] <= 1'b0;
                        idx_ff <= CW'(hslot_ff) + 1'b1;
                     end
                  end
                  pwel_pkg::MODE_RECORD: begin
                     if (!wr_en)
                        o_status_ff <= pwel_pkg::ST_IGNORED;
                     else begin
                        o_lsec_ff <= sec_ff; o_lnsec_ff <= nsec_ff;
                        o_lwait_ff <= wait_ff; o_slot_ff <= 1'b1;
                        if ($signed(sl_pwait_ff[hslot_ff]) < $signed(wait_ff)) begin
                           sl_pwait_ff[hslot_ff] <= wait_ff;
                           sl_psec_ff[hslot_ff]  <= sec_ff;
                           sl_pnsec_ff[hslot_ff] <= nsec_ff;
                        end
                        sl_pos_ff[hslot_ff] <= (sl_pos_ff[hslot_ff] == PW'(LOG_DEPTH - 1))
                                               ? '0 : sl_pos_ff[hslot_ff] + 1'b1;
                        if (sl_events_ff[hslot_ff] != 32'hFFFF_FFFF)
                           sl_events_ff[hslot_ff] <= sl_events_ff[hslot_ff] + 1'b1;
                     end
                  end
                  default: begin
                     if (!tid_pos)
                        o_status_ff <= pwel_pkg::ST_INVALID;
                     else if (!hit_ff || sl_events_ff[hslot_ff] == 32'd0)
                        o_status_ff <= pwel_pkg::ST_NOLOG;
                     else begin
                        o_slot_ff <= 1'b1;
                        if (sl_events_ff[hslot_ff] <= 32'(LOG_DEPTH)) begin
                           rnum_ff <= NW'(sl_events_ff[hslot_ff]);
                           rptr_ff <= '0;
                        end else begin
                           rnum_ff <= NW'(LOG_DEPTH);
                           rptr_ff <= sl_pos_ff[hslot_ff];
                        end
                     end
                  end
               endcase
            end
            pwel_pkg::S_HOLD: ;
            pwel_pkg::S_SHIFT: if (idx_ff < count_ff) begin
               // move one header down per cycle
               sl_thread_ff[SW'(idx_ff - 1'b1)] <= sl_thread_ff[idx_ff[SW-1:0]];
               sl_limit_ff[SW'(idx_ff - 1'b1)]  <= sl_limit_ff[idx_ff[SW-1:0]];
               sl_events_ff[SW'(idx_ff - 1'b1)] <= sl_events_ff[idx_ff[SW-1:0]];
               sl_pos_ff[SW'(idx_ff - 1'b1)]    <= sl_pos_ff[idx_ff[SW-1:0]];
               sl_pwait_ff[SW'(idx_ff - 1'b1)]  <= sl_pwait_ff[idx_ff[SW-1:0]];
               sl_psec_ff[SW'(idx_ff - 1'b1)]   <= sl_psec_ff[idx_ff[SW-1:0]];
               sl_pnsec_ff[SW'(idx_ff - 1'b1)]  <= sl_pnsec_ff[idx_ff[SW-1:0]];
               sl_buf_ff[SW'(idx_ff - 1'b1)]    <= sl_buf_ff[idx_ff[SW-1:0]];
               idx_ff <= idx_ff + 1'b1;
            end else begin
               // clear the vacated last slot
               sl_thread_ff[SW'(count_ff - 1'b1)] <= '0;
               sl_limit_ff[SW'(count_ff - 1'b1)]  <= '0;
               sl_events_ff[SW'(count_ff - 1'b1)] <= '0;
               sl_pos_ff[SW'(count_ff - 1'b1)]    <= '0;
               sl_pwait_ff[SW'(count_ff - 1'b1)]  <= '0;
               sl_psec_ff[SW'(count_ff - 1'b1)]   <= '0;
               sl_pnsec_ff[SW'(count_ff - 1'b1)]  <= '0;
               sl_buf_ff[SW'(count_ff - 1'b1)]    <= '0;
               count_ff <= count_ff - 1'b1;
            end
            pwel_pkg::S_RWAIT: begin
               o_lsec_ff  <= rd_data[39:0];
               o_lnsec_ff <= rd_data[69:40];
               o_lwait_ff <= rd_data[133:70];
               o_last_ff  <= (rnum_ff == NW'(1));
               rnum_ff    <= rnum_ff - 1'b1;
               rptr_ff    <= (rptr_ff == PW'(LOG_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule

// ----- sv/pwel_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pwel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
